### hdl/cts_pkg.sv
// ----------------------------------------------------------------------------
// cts_pkg
// Shared widths, token kind codes and record types of the token scanner.
// ----------------------------------------------------------------------------
package cts_pkg;

    // Token byte count is capped at MAX_TOKEN_BYTES-1 UTF-8 bytes
    localparam int unsigned MAX_TOKEN_BYTES = 2048;
    localparam int unsigned BYTE_W          = $clog2(MAX_TOKEN_BYTES + 1);

    localparam int unsigned CP_W         = 21;
    localparam int unsigned POS_W        = 32;
    localparam int unsigned KIND_W       = 3;
    localparam int unsigned TEXT_BYTES_W = 11;

    // Queue between lexer and output stage
    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
    localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [KIND_W-1:0] KIND_END    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_INT    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FLOAT  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_STRING = 3'd3;
    localparam logic [KIND_W-1:0] KIND_IDENT  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_ERROR  = 3'd5;
    localparam logic [KIND_W-1:0] KIND_CHAR   = 3'd6;

    typedef struct packed {
        logic [KIND_W-1:0]       token_kind;
        logic [CP_W-1:0]         char_code;
        logic [POS_W-1:0]        token_offset;
        logic [POS_W-1:0]        token_size;
        logic [TEXT_BYTES_W-1:0] text_bytes;
        logic                    truncated;
        logic                    last_of_item;
    } cts_tok_t;

    // Up to two tokens caused by one codepoint, in delivery order
    typedef struct packed {
        logic     first_valid;
        cts_tok_t first;
        logic     second_valid;
        cts_tok_t second;
    } cts_pair_t;

    typedef struct packed {
        logic [Q_CNT_W-1:0] count;
        logic               full;
        logic               empty;
    } cts_qstat_t;

endpackage

### hdl/cts_channels_if.sv
// ----------------------------------------------------------------------------
// cts channel interfaces
// Valid/ready channels for codepoints in and tokens out.
// ----------------------------------------------------------------------------
interface cts_cp_if import cts_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [CP_W-1:0] codepoint;

    modport source (output valid, output codepoint, input ready);
    modport sink   (input valid, input codepoint, output ready);
endinterface

interface cts_tok_if import cts_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [KIND_W-1:0]       token_kind;
    logic [CP_W-1:0]         char_code;
    logic [POS_W-1:0]        token_offset;
    logic [POS_W-1:0]        token_size;
    logic [TEXT_BYTES_W-1:0] text_bytes;
    logic                    truncated;
    logic                    last_of_item;

    modport source (output valid, output token_kind, output char_code, output token_offset,
                    output token_size, output text_bytes, output truncated,
                    output last_of_item, input ready);
    modport sink   (input valid, input token_kind, input char_code, input token_offset,
                    input token_size, input text_bytes, input truncated,
                    input last_of_item, output ready);
endinterface

### hdl/cts_front.sv
// ----------------------------------------------------------------------------
// cts_front
// Lexer state machine: one codepoint per cycle while the queue has room, pushes the tokens it closes.
// ----------------------------------------------------------------------------
module cts_front import cts_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    cts_cp_if.sink    text,
    output logic      push_valid,
    input  logic      push_ready,
    output cts_pair_t push_data
);

    localparam logic [2:0] M_IDLE      = 3'd0;
    localparam logic [2:0] M_IDENT     = 3'd1;
    localparam logic [2:0] M_NUM       = 3'd2;
    localparam logic [2:0] M_EXP_SIGN  = 3'd3;
    localparam logic [2:0] M_EXP_CHECK = 3'd4;
    localparam logic [2:0] M_RADIX     = 3'd5;
    localparam logic [2:0] M_STRING    = 3'd6;
    localparam logic [2:0] M_MINUS     = 3'd7;

    localparam int unsigned CAP   = MAX_TOKEN_BYTES - 1;
    localparam int unsigned CMP_W = BYTE_W + 3;

    localparam logic [CP_W-1:0] CP_TAB    = 21'h09;
    localparam logic [CP_W-1:0] CP_LF     = 21'h0A;
    localparam logic [CP_W-1:0] CP_CR     = 21'h0D;
    localparam logic [CP_W-1:0] CP_SPACE  = 21'h20;
    localparam logic [CP_W-1:0] CP_QUOTE  = 21'h22;
    localparam logic [CP_W-1:0] CP_PLUS   = 21'h2B;
    localparam logic [CP_W-1:0] CP_MINUS  = 21'h2D;
    localparam logic [CP_W-1:0] CP_DOT    = 21'h2E;
    localparam logic [CP_W-1:0] CP_ZERO   = 21'h30;
    localparam logic [CP_W-1:0] CP_ONE    = 21'h31;
    localparam logic [CP_W-1:0] CP_UP_B   = 21'h42;
    localparam logic [CP_W-1:0] CP_UP_E   = 21'h45;
    localparam logic [CP_W-1:0] CP_UP_X   = 21'h58;
    localparam logic [CP_W-1:0] CP_BSLASH = 21'h5C;
    localparam logic [CP_W-1:0] CP_LO_B   = 21'h62;
    localparam logic [CP_W-1:0] CP_LO_E   = 21'h65;
    localparam logic [CP_W-1:0] CP_LO_X   = 21'h78;
    localparam logic [CP_W-1:0] CP_NUL    = 21'h00;

    typedef struct packed {
        logic [POS_W-1:0]  len;
        logic [BYTE_W-1:0] bytes;
        logic              ovf;
    } cnt_t;

    function automatic logic [2:0] utf8_len(input logic [CP_W-1:0] cp);
        logic [2:0] n;
        if (cp < 21'h80)
            n = 3'd1;
        else if (cp < 21'h800)
            n = 3'd2;
        else if (cp < 21'h10000)
            n = 3'd3;
        else
            n = 3'd4;
        return n;
    endfunction

    // Append one codepoint to the token counters
    function automatic cnt_t take(input cnt_t c, input logic [2:0] need);
        cnt_t             r;
        logic [CMP_W-1:0] room;
        logic [CMP_W-1:0] sum;
        r    = c;
        room = CMP_W'(CAP) - CMP_W'(c.bytes);
        sum  = CMP_W'(c.bytes) + CMP_W'(need);
        if (!c.ovf)
        begin
            if (CMP_W'(need) > room)
                r.ovf = 1'b1;
            else
                r.bytes = BYTE_W'(sum);
        end
        if (c.len != {POS_W{1'b1}})
            r.len = c.len + POS_W'(1);
        return r;
    endfunction

    logic [2:0]       mode_reg, mode_next;
    logic             zp_reg, zp_next;
    logic             hex_reg, hex_next;
    logic             seen_reg, seen_next;
    logic             frac_reg, frac_next;
    logic             exp_reg, exp_next;
    logic             bad_reg, bad_next;
    logic             float_reg, float_next;
    logic             esc_reg, esc_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] start_reg, start_next;
    cnt_t             cnt_reg, cnt_next;

    logic [CP_W-1:0]   cp;
    logic              accept;
    logic              is_dec, is_hex, is_alpha, is_ws, is_radix, is_exp;
    logic [2:0]        need;
    cnt_t              tk;
    cnt_t              r1_cnt;
    logic              used, done, ended, nf, nb, radix_ok;
    logic              emit1, emit2;
    logic [KIND_W-1:0] kind1, kind2;
    logic [CP_W-1:0]   code1, code2;

    assign cp       = text.codepoint;
    assign accept   = text.valid && push_ready;
    assign text.ready = push_ready;

    assign is_dec   = (cp >= CP_ZERO) && (cp <= 21'h39);
    assign is_hex   = is_dec || ((cp >= 21'h61) && (cp <= 21'h66))
                      || ((cp >= 21'h41) && (cp <= 21'h46));
    assign is_alpha = ((cp >= 21'h61) && (cp <= 21'h7A))
                      || ((cp >= 21'h41) && (cp <= 21'h5A)) || (cp == 21'h5F);
    assign is_ws    = (cp == CP_SPACE) || (cp == CP_TAB) || (cp == CP_CR) || (cp == CP_LF);
    assign is_radix = (cp == CP_LO_X) || (cp == CP_UP_X) || (cp == CP_LO_B) || (cp == CP_UP_B);
    assign is_exp   = (cp == CP_LO_E) || (cp == CP_UP_E);
    assign need     = utf8_len(cp);
    assign tk       = take(cnt_reg, need);

    always_comb
    begin
        mode_next  = mode_reg;
        zp_next    = zp_reg;
        hex_next   = hex_reg;
        seen_next  = seen_reg;
        frac_next  = frac_reg;
        exp_next   = exp_reg;
        bad_next   = bad_reg;
        float_next = float_reg;
        esc_next   = esc_reg;
        start_next = start_reg;
        cnt_next   = cnt_reg;
        used       = 1'b0;
        done       = 1'b0;
        ended      = 1'b0;
        nf         = float_reg;
        nb         = bad_reg;
        radix_ok   = hex_reg ? is_hex : ((cp == CP_ZERO) || (cp == CP_ONE));
        emit1      = 1'b0;
        kind1      = KIND_END;
        code1      = '0;
        emit2      = 1'b0;
        kind2      = KIND_END;
        code2      = '0;

        case (mode_reg)
            M_IDENT:
            begin
                if (is_alpha || is_dec)
                begin
                    cnt_next = tk;
                    used     = 1'b1;
                end
                else
                begin
                    emit1 = 1'b1;
                    kind1 = KIND_IDENT;
                end
            end
            M_MINUS:
            begin
                if (is_dec)
                begin
                    cnt_next  = tk;
                    mode_next = M_NUM;
                    zp_next   = (cp == CP_ZERO);
                    used      = 1'b1;
                end
                else
                begin
                    emit1 = 1'b1;
                    kind1 = KIND_CHAR;
                    code1 = CP_MINUS;
                end
            end
            M_RADIX:
            begin
                if (radix_ok)
                begin
                    cnt_next  = tk;
                    seen_next = 1'b1;
                    used      = 1'b1;
                end
                else
                begin
                    emit1 = 1'b1;
                    kind1 = seen_reg ? KIND_INT : KIND_ERROR;
                end
            end
            M_STRING:
            begin
                if (cp == CP_NUL)
                begin
                    emit1 = 1'b1;
                    kind1 = KIND_STRING;
                end
                else
                begin
                    if (esc_reg)
                        esc_next = 1'b0;
                    else if (cp == CP_BSLASH)
                        esc_next = 1'b1;
                    else if (cp == CP_QUOTE)
                        done = 1'b1;
                    cnt_next = tk;
                    used     = 1'b1;
                    emit1    = done;
                    kind1    = KIND_STRING;
                end
            end
            M_NUM, M_EXP_SIGN, M_EXP_CHECK:
            begin
                if ((mode_reg == M_EXP_SIGN) && ((cp == CP_PLUS) || (cp == CP_MINUS)))
                begin
                    cnt_next  = tk;
                    mode_next = M_EXP_CHECK;
                    used      = 1'b1;
                end
                else
                begin
                    if (mode_reg != M_NUM)
                    begin
                        if (is_dec)
                            nf = 1'b1;
                        else
                            nb = 1'b1;
                    end
                    mode_next  = M_NUM;
                    float_next = nf;
                    bad_next   = nb;
                    if (zp_reg)
                    begin
                        zp_next = 1'b0;
                        if (is_radix)
                        begin
                            hex_next  = (cp == CP_LO_X) || (cp == CP_UP_X);
                            seen_next = 1'b0;
                            cnt_next  = tk;
                            mode_next = M_RADIX;
                            used      = 1'b1;
                        end
                    end
                    if (!used)
                    begin
                        if (is_dec)
                        begin
                            cnt_next = tk;
                            used     = 1'b1;
                        end
                        else if ((cp == CP_DOT) && !frac_reg)
                        begin
                            frac_next  = 1'b1;
                            float_next = 1'b1;
                            cnt_next   = tk;
                            used       = 1'b1;
                        end
                        else if (is_exp && !exp_reg)
                        begin
                            exp_next  = 1'b1;
                            cnt_next  = tk;
                            mode_next = M_EXP_SIGN;
                            used      = 1'b1;
                        end
                        else
                        begin
                            emit1 = 1'b1;
                            kind1 = nb ? KIND_ERROR : (nf ? KIND_FLOAT : KIND_INT);
                        end
                    end
                end
            end
            default:
            begin
                mode_next = M_IDLE;
            end
        endcase

        // closing token reports the counters as they stand after this step
        r1_cnt = cnt_next;
        if (emit1)
            mode_next = M_IDLE;

        // codepoint not absorbed: it opens a new token
        if (!used)
        begin
            start_next = pos_reg;
            zp_next    = 1'b0;
            hex_next   = 1'b0;
            seen_next  = 1'b0;
            frac_next  = 1'b0;
            exp_next   = 1'b0;
            bad_next   = 1'b0;
            float_next = 1'b0;
            esc_next   = 1'b0;
            cnt_next   = '0;
            mode_next  = M_IDLE;
            if (cp == CP_NUL)
            begin
                emit2 = 1'b1;
                kind2 = KIND_END;
                ended = 1'b1;
            end
            else if (!is_ws)
            begin
                cnt_next = take(cnt_t'('0), need);
                if (cp == CP_QUOTE)
                    mode_next = M_STRING;
                else if (is_dec)
                begin
                    mode_next = M_NUM;
                    zp_next   = (cp == CP_ZERO);
                end
                else if (is_alpha)
                    mode_next = M_IDENT;
                else if (cp == CP_MINUS)
                    mode_next = M_MINUS;
                else
                begin
                    emit2 = 1'b1;
                    kind2 = KIND_CHAR;
                    code2 = cp;
                end
            end
        end

        pos_next = ended ? '0 : pos_reg + POS_W'(1);
    end

    always_comb
    begin
        push_data.first_valid         = emit1;
        push_data.first.token_kind    = kind1;
        push_data.first.char_code     = code1;
        push_data.first.token_offset  = start_reg;
        push_data.first.token_size    = r1_cnt.len;
        push_data.first.text_bytes    = TEXT_BYTES_W'(r1_cnt.bytes);
        push_data.first.truncated     = r1_cnt.ovf;
        push_data.first.last_of_item  = !emit2;
        push_data.second_valid        = emit2;
        push_data.second.token_kind   = kind2;
        push_data.second.char_code    = code2;
        push_data.second.token_offset = start_next;
        push_data.second.token_size   = cnt_next.len;
        push_data.second.text_bytes   = TEXT_BYTES_W'(cnt_next.bytes);
        push_data.second.truncated    = cnt_next.ovf;
        push_data.second.last_of_item = 1'b1;
    end

    assign push_valid = accept && (emit1 || emit2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= M_IDLE;
            zp_reg    <= 1'b0;
            hex_reg   <= 1'b0;
            seen_reg  <= 1'b0;
            frac_reg  <= 1'b0;
            exp_reg   <= 1'b0;
            bad_reg   <= 1'b0;
            float_reg <= 1'b0;
            esc_reg   <= 1'b0;
            pos_reg   <= '0;
            start_reg <= '0;
            cnt_reg   <= '0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            zp_reg    <= zp_next;
            hex_reg   <= hex_next;
            seen_reg  <= seen_next;
            frac_reg  <= frac_next;
            exp_reg   <= exp_next;
            bad_reg   <= bad_next;
            float_reg <= float_next;
            esc_reg   <= esc_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

### hdl/cts_queue.sv
// ----------------------------------------------------------------------------
// cts_queue
// Small register FIFO of token pairs between lexer and output stage.
// ----------------------------------------------------------------------------
module cts_queue import cts_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push_valid,
    input  cts_pair_t  push_data,
    output logic       push_ready,
    output logic       pop_valid,
    output cts_pair_t  pop_data,
    input  logic       pop_ready,
    output cts_qstat_t status
);

    cts_pair_t          mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg, count_next;
    logic               do_push, do_pop;

    assign status.count = count_reg;
    assign status.full  = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign status.empty = (count_reg == '0);

    assign push_ready = !status.full;
    assign pop_valid  = !status.empty;
    assign pop_data   = mem_reg[rd_ptr_reg];

    assign do_push = push_valid && push_ready;
    assign do_pop  = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0
                          : wr_ptr_reg + Q_PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0
                          : rd_ptr_reg + Q_PTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + Q_CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - Q_CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

### hdl/cts_back.sv
// ----------------------------------------------------------------------------
// cts_back
// Output stage: splits queued token pairs into single token transactions.
// ----------------------------------------------------------------------------
module cts_back import cts_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      pop_valid,
    input  cts_pair_t pop_data,
    output logic      pop_ready,
    cts_tok_if.source tokens
);

    logic     out_valid_reg, out_valid_next;
    cts_tok_t out_reg, out_next;
    logic     sec_valid_reg, sec_valid_next;
    cts_tok_t sec_reg, sec_next;
    logic     load;

    // output register may take a new token when empty or being drained
    assign load      = !out_valid_reg || tokens.ready;
    assign pop_ready = load && !sec_valid_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        sec_valid_next = sec_valid_reg;
        sec_next       = sec_reg;
        if (load)
        begin
            out_valid_next = 1'b0;
            if (sec_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_next       = sec_reg;
                sec_valid_next = 1'b0;
            end
            else if (pop_valid)
            begin
                out_valid_next = 1'b1;
                if (pop_data.first_valid)
                begin
                    out_next       = pop_data.first;
                    sec_valid_next = pop_data.second_valid;
                    sec_next       = pop_data.second;
                end
                else
                    out_next = pop_data.second;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sec_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            sec_valid_reg <= sec_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        sec_reg <= sec_next;
    end

    assign tokens.valid        = out_valid_reg;
    assign tokens.token_kind   = out_reg.token_kind;
    assign tokens.char_code    = out_reg.char_code;
    assign tokens.token_offset = out_reg.token_offset;
    assign tokens.token_size   = out_reg.token_size;
    assign tokens.text_bytes   = out_reg.text_bytes;
    assign tokens.truncated    = out_reg.truncated;
    assign tokens.last_of_item = out_reg.last_of_item;

endmodule

### hdl/codepoint_token_scanner.sv
// ----------------------------------------------------------------------------
// codepoint_token_scanner
// Streaming lexer: codepoints in, classified token descriptors out.
// ----------------------------------------------------------------------------
// Usage:
//   text   : one codepoint per transaction; 0 marks the end of the text.
//   tokens : one token descriptor per transaction; last_of_item flags the
//            final token caused by a given codepoint (at most two).
//   A codepoint is taken every cycle while the four-entry pair queue has
//   room. The lexer state machine reports a token on the codepoint that
//   closes it; that token is written into the pair queue when the codepoint
//   is taken, then loaded into the output register, which presents it on
//   tokens. A second token from the same codepoint waits in the output
//   stage's second-token register and follows it.
//   Sustained rate: one codepoint per cycle in while the queue has room, one
//   token per cycle out while the receiver is ready; a codepoint that yields
//   two tokens holds the output for both, and the queue absorbs such bursts.
//   Whitespace and the inner characters of tokens produce nothing.
//   Reset clears the lexer to idle between tokens, the text position to 0
//   and empties the queue. If the receiver stalls, the output register
//   holds its token, the queue fills, and text.ready drops once it is full.
// ----------------------------------------------------------------------------
module codepoint_token_scanner import cts_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    cts_cp_if.sink    text,
    cts_tok_if.source tokens
);

    // lexer -> queue
    logic       push_valid;
    logic       push_ready;
    cts_pair_t  push_data;

    // queue -> output stage
    logic       pop_valid;
    logic       pop_ready;
    cts_pair_t  pop_data;
    cts_qstat_t q_stat;

    // Front: state machine, consumes a codepoint whenever the queue has room
    cts_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .text       (text),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // Decoupling queue of token pairs
    cts_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_data   (pop_data),
        .pop_ready  (pop_ready),
        .status     (q_stat)
    );

    // Back: serializes pairs onto the token channel
    cts_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_data  (pop_data),
        .pop_ready (pop_ready),
        .tokens    (tokens)
    );

    // Queue occupancy never passes its depth
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.count <= Q_CNT_W'(Q_DEPTH))
        else $error("token pair queue overrun");

    // End token carries no length and no truncation
    a_end_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (tokens.valid && (tokens.token_kind == KIND_END)) |->
        ((tokens.token_size == '0) && (tokens.text_bytes == '0) && !tokens.truncated))
        else $error("end token with nonzero size");

    // Single character tokens are exactly one codepoint long
    a_char_size: assert property (@(posedge clk) disable iff (!rst_n)
        (tokens.valid && (tokens.token_kind == KIND_CHAR)) |->
        (tokens.token_size == POS_W'(1)))
        else $error("single character token with wrong size");

    // Only single character tokens carry a code
    a_code_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (tokens.valid && (tokens.token_kind != KIND_CHAR)) |-> (tokens.char_code == '0))
        else $error("char_code set on non-character token");

endmodule
